// File: rtl/sha1sh_pkg.sv
// Shared types and constants of the byte-serial SHA-1 hasher.
package sha1sh_pkg;

    localparam int unsigned NUM_CHAIN  = 5;
    localparam int unsigned NUM_SCHED  = 16;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [2:0]  LAST_INDEX = 3'd4;
    localparam logic [5:0]  LAST_POS   = 6'd63;
    localparam logic [5:0]  LEN_POS    = 6'd56;
    localparam logic [7:0]  PAD_MARK   = 8'h80;

    localparam logic [31:0] INIT_CHAIN [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_P2  = 32'hCA62C1D6;

    // Chaining words, word 0 (h0) at index 0
    typedef logic [NUM_CHAIN-1:0][31:0] chain_t;

    // Commands from the sequencer to the compression unit
    typedef struct packed {
        logic       byte_we;
        logic [3:0] word_addr;
        logic [1:0] lane;
        logic [7:0] byte_val;
        logic       start;
        logic       chain_init;
    } cmd_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PAD   = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // Padding phases
    typedef enum logic [2:0] {
        PH_MARK = 3'b001,
        PH_ZERO = 3'b010,
        PH_LEN  = 3'b100
    } pad_phase_t;

endpackage

// File: rtl/sha1sh_compress.sv
// SHA-1 compression unit: block buffer as message schedule, one round per cycle.
module sha1sh_compress (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1sh_pkg::cmd_t    cmd,
    output logic                done,
    output sha1sh_pkg::chain_t  chain
);

    logic [31:0] sched_reg [sha1sh_pkg::NUM_SCHED];
    logic [31:0] work_reg  [sha1sh_pkg::NUM_CHAIN];
    logic [31:0] work_next [sha1sh_pkg::NUM_CHAIN];
    logic [31:0] chain_reg [sha1sh_pkg::NUM_CHAIN];
    logic [6:0]  round_reg;
    logic        running_reg;
    logic        fold_reg;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] sum_val;
    logic [31:0] w_new;
    logic [31:0] w_mix;
    logic [4:0]  lane_off;

    // Select the round function and constant by round group
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = sha1sh_pkg::K_CH;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1sh_pkg::K_P1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
            k_val = sha1sh_pkg::K_MAJ;
        end
        else
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = sha1sh_pkg::K_P2;
        end
    end

    // Round datapath and schedule expansion
    always_comb
    begin
        sum_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4]
                + k_val + sched_reg[0];
        work_next[0] = sum_val;
        work_next[1] = work_reg[0];
        work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
        work_next[3] = work_reg[2];
        work_next[4] = work_reg[3];
        w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_new = {w_mix[30:0], w_mix[31]};
        lane_off = {~cmd.lane, 3'b000};
    end

    // Sequence the rounds and the final fold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg   <= '0;
            running_reg <= 1'b0;
            fold_reg    <= 1'b0;
        end
        else
        begin
            fold_reg <= 1'b0;
            if (cmd.start)
            begin
                round_reg   <= '0;
                running_reg <= 1'b1;
            end
            else if (running_reg)
            begin
                round_reg <= round_reg + 7'd1;
                if (round_reg == sha1sh_pkg::LAST_ROUND)
                begin
                    running_reg <= 1'b0;
                    fold_reg    <= 1'b1;
                end
            end
        end
    end

    // Load and advance the working words
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (running_reg)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
                work_reg[i] <= work_next[i];
        end
    end

    // Fill the block buffer byte by byte; shift it as the schedule window
    always_ff @(posedge clk)
    begin
        if (running_reg)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_SCHED - 1; i++)
                sched_reg[i] <= sched_reg[i+1];
            sched_reg[sha1sh_pkg::NUM_SCHED-1] <= w_new;
        end
        else if (cmd.byte_we)
        begin
            sched_reg[cmd.word_addr][lane_off +: 8] <= cmd.byte_val;
        end
    end

    // Hold the chaining words; fold in the round result at block end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
                chain_reg[i] <= sha1sh_pkg::INIT_CHAIN[i];
        end
        else if (cmd.chain_init)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
                chain_reg[i] <= sha1sh_pkg::INIT_CHAIN[i];
        end
        else if (fold_reg)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
                chain_reg[i] <= chain_reg[i] + work_reg[i];
        end
    end

    // Present status and chaining words
    always_comb
    begin
        done = fold_reg;
        for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
            chain[i] = chain_reg[i];
    end

endmodule

// File: rtl/sha1_stream_hasher_core.sv
// Byte-serial SHA-1 hasher: input sequencer, padding and digest output.
//
// Input channel (s_*): one transaction carries at most one message byte
// (tdata, valid when tuser is 1) and may close the message (tlast). A byte
// transaction that fills a 64-byte block starts the compression unit: it
// runs 80 rounds, one a cycle, then adds the result into the chaining
// words, and s_tready stays low until it is done.
// Closing a message appends the padding one byte a cycle (9 to 72 bytes)
// with one or two block compressions before the first digest word is valid.
// Output channel (m_*): five transactions per message, digest word h0 to h4
// on tdata, its index on tuser, tlast on the fifth. The digest sits in its
// own output bank, so the next message is taken while it drains; only if a
// further digest is ready before the bank is empty does the block wait,
// holding s_tready low, until the receiver has taken the fifth word.
// Reset returns the chaining words to the initial values, clears the byte
// count and drops any pending digest.
module sha1_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    sha1sh_pkg::state_t     state_reg;
    sha1sh_pkg::state_t     state_next;
    sha1sh_pkg::pad_phase_t phase_reg;
    sha1sh_pkg::pad_phase_t phase_next;
    logic                   pad_active_reg;
    logic                   pad_active_next;
    logic [60:0]            count_reg;
    logic [60:0]            count_next;
    logic [63:0]            bits_reg;
    logic [63:0]            bits_next;
    logic [31:0]            out_words_reg [sha1sh_pkg::NUM_CHAIN];
    logic [2:0]             out_idx_reg;
    logic                   out_busy_reg;
    logic [60:0]            count_after;
    logic [5:0]             pos;
    logic                   in_fire;
    logic                   out_fire;
    logic                   out_load;
    logic [7:0]             pad_byte;
    logic                   comp_done;
    sha1sh_pkg::chain_t     chain;
    sha1sh_pkg::cmd_t       cmd;

    sha1sh_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .done  (comp_done),
        .chain (chain)
    );

    assign pos         = count_reg[5:0];
    assign s_tready    = (state_reg == sha1sh_pkg::ST_IDLE);
    assign in_fire     = s_tvalid & s_tready;
    assign out_fire    = m_tvalid & m_tready;
    assign out_load    = (state_reg == sha1sh_pkg::ST_EMIT) & ~out_busy_reg;
    assign count_after = count_reg + {60'd0, s_tuser};

    // Pick the next padding byte
    always_comb
    begin
        pad_byte   = 8'd0;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        if (phase_reg == sha1sh_pkg::PH_MARK)
        begin
            pad_byte   = sha1sh_pkg::PAD_MARK;
            phase_next = sha1sh_pkg::PH_ZERO;
        end
        else if ((phase_reg == sha1sh_pkg::PH_ZERO) && (pos != sha1sh_pkg::LEN_POS))
        begin
            pad_byte = 8'd0;
        end
        else
        begin
            pad_byte   = bits_reg[63:56];
            bits_next  = {bits_reg[55:0], 8'd0};
            phase_next = sha1sh_pkg::PH_LEN;
        end
    end

    // Sequence byte writes, padding, compression and digest hand-off
    always_comb
    begin
        state_next      = state_reg;
        pad_active_next = pad_active_reg;
        count_next      = count_reg;
        cmd             = '0;
        cmd.word_addr   = pos[5:2];
        cmd.lane        = pos[1:0];
        cmd.byte_val    = s_tdata;
        case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.byte_we     = s_tuser;
                    count_next      = count_after;
                    pad_active_next = s_tlast;
                    if (s_tuser && (pos == sha1sh_pkg::LAST_POS))
                    begin
                        cmd.start  = 1'b1;
                        state_next = sha1sh_pkg::ST_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        state_next = sha1sh_pkg::ST_PAD;
                    end
                end
            end
            sha1sh_pkg::ST_PAD:
            begin
                cmd.byte_we  = 1'b1;
                cmd.byte_val = pad_byte;
                count_next   = count_reg + 61'd1;
                if (pos == sha1sh_pkg::LAST_POS)
                begin
                    cmd.start  = 1'b1;
                    state_next = sha1sh_pkg::ST_ROUND;
                end
            end
            sha1sh_pkg::ST_ROUND:
            begin
                if (comp_done)
                begin
                    if (pad_active_reg && (phase_reg == sha1sh_pkg::PH_LEN))
                        state_next = sha1sh_pkg::ST_EMIT;
                    else if (pad_active_reg)
                        state_next = sha1sh_pkg::ST_PAD;
                    else
                        state_next = sha1sh_pkg::ST_IDLE;
                end
            end
            sha1sh_pkg::ST_EMIT:
            begin
                if (!out_busy_reg)
                begin
                    cmd.chain_init  = 1'b1;
                    count_next      = '0;
                    pad_active_next = 1'b0;
                    state_next      = sha1sh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha1sh_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sha1sh_pkg::ST_IDLE;
            phase_reg      <= sha1sh_pkg::PH_MARK;
            pad_active_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pad_active_reg <= pad_active_next;
            count_reg      <= count_next;
            if (in_fire)
                phase_reg <= sha1sh_pkg::PH_MARK;
            else if (state_reg == sha1sh_pkg::ST_PAD)
                phase_reg <= phase_next;
        end
    end

    // Latch the bit length on every input transaction; shift it out while padding
    always_ff @(posedge clk)
    begin
        if (in_fire)
            bits_reg <= {count_after, 3'b000};
        else if (state_reg == sha1sh_pkg::ST_PAD)
            bits_reg <= bits_next;
    end

    // Track the output bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_busy_reg <= 1'b0;
            out_idx_reg  <= '0;
        end
        else if (out_load)
        begin
            out_busy_reg <= 1'b1;
            out_idx_reg  <= '0;
        end
        else if (out_fire)
        begin
            out_idx_reg <= out_idx_reg + 3'd1;
            if (out_idx_reg == sha1sh_pkg::LAST_INDEX)
                out_busy_reg <= 1'b0;
        end
    end

    // Load the digest and advance it one word per output transaction
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_CHAIN; i++)
                out_words_reg[i] <= chain[i];
        end
        else if (out_fire)
        begin
            for (int i = 0; i < sha1sh_pkg::NUM_CHAIN - 1; i++)
                out_words_reg[i] <= out_words_reg[i+1];
        end
    end

    assign m_tvalid = out_busy_reg;
    assign m_tdata  = out_words_reg[0];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == sha1sh_pkg::LAST_INDEX);

endmodule
